FILE: design/sdgd_pkg.sv
// ----------------------------------------------------------------------------
// sdgd_pkg
// Shared types, codes and constants of the slow-data GPS deframer.
// ----------------------------------------------------------------------------
package sdgd_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   // action codes of a request
   localparam logic [1:0] ACT_HEADER = 2'd0;
   localparam logic [1:0] ACT_VOICE  = 2'd1;
   localparam logic [1:0] ACT_EOT    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_KEY  = 2'd0;
   localparam logic [1:0] CSR_MASK = 2'd1;
   localparam logic [1:0] CSR_GPS  = 2'd2;

   localparam logic [23:0] KEY_RESET  = 24'h704F93;
   localparam logic [7:0]  MASK_RESET = 8'hF0;
   localparam logic [7:0]  GPS_RESET  = 8'h30;

   localparam logic [31:0] EOB_HEAD    = 32'h5B454F42;
   localparam logic [7:0]  EOB_TAIL    = 8'h5D;
   localparam logic [2:0]  MAX_PAYLOAD = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic latch_item;   // capture the accepted request
      logic clear_phase;  // restart pairing
      logic store_half;   // keep first half, expect second
      logic load_block;   // build the block from both halves
      logic step_byte;    // a payload byte was taken
      logic flush;        // the flush result was taken
      logic show_flush;   // present the flush result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] action;
      logic       frame_ok;
      logic       is_sync;
      logic       is_end;
      logic       phase;
      logic       gps_hit;
      logic       count_nz;
      logic       pending;
      logic       last_byte;
   } status_type;

endpackage

FILE: design/sdgd_ctrl.sv
// ----------------------------------------------------------------------------
// sdgd_ctrl
// Sequencer: accepts one request, decides its outcome, emits its results.
// ----------------------------------------------------------------------------
module sdgd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sdgd_pkg::status_type  status,
   output sdgd_pkg::cmd_type     cmd
);
   import sdgd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      flush_due;
   logic      pair_done;

   always_comb begin
      flush_due = status.pending;
      pair_done = status.gps_hit && status.count_nz;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            unique case (status.action) inside
               ACT_HEADER, ACT_EOT: begin
                  if (flush_due) state_in = ST_FLUSH;
               end
               ACT_VOICE: begin
                  if (status.is_sync) begin
                     state_in = ST_IDLE;
                  end else if (status.is_end) begin
                     if (flush_due) state_in = ST_FLUSH;
                  end else if (status.frame_ok && status.phase && pair_done) begin
                     state_in = ST_EMIT;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_EMIT: begin
            if (rsp_tready && status.last_byte) state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.latch_item = req_tvalid;
         end
         ST_EVAL: begin
            if (status.action == ACT_HEADER) cmd.clear_phase = 1'b1;
            if (status.action == ACT_VOICE) begin
               if (status.is_sync) begin
                  cmd.clear_phase = 1'b1;
               end else if (!status.is_end && status.frame_ok) begin
                  cmd.store_half = !status.phase;
                  cmd.load_block = status.phase;
               end
            end
         end
         ST_EMIT: begin
            rsp_tvalid    = 1'b1;
            cmd.step_byte = rsp_tready;
         end
         ST_FLUSH: begin
            rsp_tvalid     = 1'b1;
            cmd.show_flush = 1'b1;
            cmd.flush      = rsp_tready;
         end
         default: begin
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/sdgd_datapath.sv
// ----------------------------------------------------------------------------
// sdgd_datapath
// Registers, descrambler, block pairing and end-of-block text match.
// ----------------------------------------------------------------------------
module sdgd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sdgd_pkg::cmd_type     cmd,
   output sdgd_pkg::status_type  status,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_data,
   input  logic [23:0]           req_tdata,  // slow_byte_0, slow_byte_1, slow_byte_2
   input  logic [3:0]            req_tuser,  // action[1:0], frame_ok, is_sync
   input  logic                  req_tlast,  // is_end
   output logic [7:0]            rsp_tdata,  // out_byte
   output logic [1:0]            rsp_tuser,  // byte_valid, message_end
   output logic                  rsp_tlast   // last_of_input
);
   import sdgd_pkg::*;

   logic [23:0] key_ff,  key_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  gps_ff,  gps_in;

   logic [1:0]  action_ff;
   logic        ok_ff, sync_ff, end_ff;
   logic [23:0] half_ff;

   logic        phase_ff,   phase_in;
   logic [23:0] held_ff,    held_in;
   logic [4:0][7:0] blk_ff, blk_in;
   logic [2:0]  count_ff,   count_in;
   logic [2:0]  idx_ff,     idx_in;
   logic [31:0] recent_ff,  recent_in;
   logic        pending_ff, pending_in;

   logic [2:0]  raw_count;
   logic [7:0]  cur_byte;
   logic        hit;

   always_comb begin
      raw_count = held_ff[18:16];
      case (idx_ff)
         3'd0:    cur_byte = blk_ff[0];
         3'd1:    cur_byte = blk_ff[1];
         3'd2:    cur_byte = blk_ff[2];
         3'd3:    cur_byte = blk_ff[3];
         default: cur_byte = blk_ff[4];
      endcase
      hit = (recent_ff == EOB_HEAD) && (cur_byte == EOB_TAIL);
   end

   always_comb begin
      key_in  = key_ff;
      mask_in = mask_ff;
      gps_in  = gps_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY:  key_in  = csr_data;
            CSR_MASK: mask_in = csr_data[7:0];
            CSR_GPS:  gps_in  = csr_data[7:0];
            default:  key_in  = key_ff;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      blk_in     = blk_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      recent_in  = recent_ff;
      pending_in = pending_ff;
      if (cmd.clear_phase) phase_in = 1'b0;
      if (cmd.store_half) begin
         held_in  = half_ff;
         phase_in = 1'b1;
      end
      if (cmd.load_block) begin
         phase_in = 1'b0;
         blk_in   = {half_ff[7:0], half_ff[15:8], half_ff[23:16],
                     held_ff[7:0], held_ff[15:8]};
         count_in = (raw_count > MAX_PAYLOAD) ? MAX_PAYLOAD : raw_count;
         idx_in   = '0;
      end
      if (cmd.step_byte) begin
         idx_in = idx_ff + 3'd1;
         if (hit) begin
            recent_in  = '0;
            pending_in = 1'b0;
         end else begin
            recent_in  = {recent_ff[23:0], cur_byte};
            pending_in = 1'b1;
         end
      end
      if (cmd.flush) begin
         recent_in  = '0;
         pending_in = 1'b0;
      end
   end

   always_comb begin
      status.action    = action_ff;
      status.frame_ok  = ok_ff;
      status.is_sync   = sync_ff;
      status.is_end    = end_ff;
      status.phase     = phase_ff;
      status.gps_hit   = (held_ff[23:16] & mask_ff) == gps_ff;
      status.count_nz  = raw_count != 3'd0;
      status.pending   = pending_ff;
      status.last_byte = (idx_ff + 3'd1) == count_ff;
   end

   always_comb begin
      if (cmd.show_flush) begin
         rsp_tdata = '0;
         rsp_tuser = 2'b10;
         rsp_tlast = 1'b1;
      end else begin
         rsp_tdata = cur_byte;
         rsp_tuser = {hit, 1'b1};
         rsp_tlast = status.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= KEY_RESET;
         mask_ff    <= MASK_RESET;
         gps_ff     <= GPS_RESET;
         phase_ff   <= 1'b0;
         held_ff    <= '0;
         recent_ff  <= '0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
         idx_ff     <= '0;
      end else begin
         key_ff     <= key_in;
         mask_ff    <= mask_in;
         gps_ff     <= gps_in;
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         recent_ff  <= recent_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (cmd.latch_item) begin
         action_ff <= req_tuser[1:0];
         ok_ff     <= req_tuser[2];
         sync_ff   <= req_tuser[3];
         end_ff    <= req_tlast;
         half_ff   <= {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]} ^ key_ff;
      end
   end

endmodule

FILE: design/slow_data_gps_deframer.sv
// ----------------------------------------------------------------------------
// slow_data_gps_deframer
// Timing: a request is taken in the idle state and evaluated in the next
//   cycle; the first result, if any, is then presented from the emit or flush state.
// Flow: one request is handled at a time; a new one is taken only after every
//   result of the last has been taken, so requests wait on the serial byte emitter.
// Reset: synchronous, active high; registers return to their reset values,
//   pairing restarts and nothing is pending.
// ----------------------------------------------------------------------------
module slow_data_gps_deframer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // slow_byte_0, slow_byte_1, slow_byte_2
   input  logic [3:0]  req_tuser,   // action[1:0], frame_ok, is_sync
   input  logic        req_tlast,   // is_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic [1:0]  rsp_tuser,   // byte_valid, message_end
   output logic        rsp_tlast,   // last_of_input
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import sdgd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Registers are plain flops: take a write in any cycle.
   assign csr_ready = 1'b1;

   // Controller: idle, evaluate the held request, then stream bytes or
   // present the flush result, one per handshake.
   sdgd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: hold the request, descramble, pair halves, match the
   // end-of-block text over the emitted stream.
   sdgd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // Never take a request while a result is still on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a result is pending");

   // A result without a byte is always the closing flush.
   a_flush_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] && rsp_tlast && rsp_tdata == 8'd0)
      else $error("malformed flush result");

   // After a request is taken the block must evaluate before taking another.
   a_eval_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("request not evaluated before the next one");
`endif

endmodule

FILE: test/sdgd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdgd_checker
// Watches the request, result and register channels of the GPS deframer,
// predicts the payload bytes and message ends of each accepted request, and
// compares every accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module sdgd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // slow_byte_0, slow_byte_1, slow_byte_2
   input  logic [3:0]  req_tuser,   // action[1:0], frame_ok, is_sync
   input  logic        req_tlast,   // is_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_byte
   input  logic [1:0]  rsp_tuser,   // byte_valid, message_end
   input  logic        rsp_tlast,   // last_of_input
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          outstanding
);
   import sdgd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       message_end;
      logic       tail;
   } gps_result_type;

   gps_result_type gps_out_q[$];

   logic [23:0] key;
   logic [7:0]  mask;
   logic [7:0]  gps;
   logic        phase;
   logic [23:0] held;
   logic [31:0] recent;
   logic        pending;
   int          errors = 0;

   assign fail_count = errors;

   function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
   endfunction

   task automatic flush_message();
      if (pending) begin
         gps_out_q.push_back('{data: 8'h00, byte_valid: 1'b0, message_end: 1'b1, tail: 1'b1});
      end
      pending = 1'b0;
      recent  = '0;
   endtask

   task automatic deframe_request(input logic [1:0] act, input logic ok, input logic sync,
                                  input logic endf, input logic [23:0] slow);
      logic [23:0] half;
      logic [47:0] block;
      logic [7:0]  b;
      logic        hit;
      int          cnt;
      if (act == ACT_HEADER) begin
         phase = 1'b0;
         flush_message();
      end else if (act == ACT_EOT) begin
         flush_message();
      end else if (act == ACT_VOICE) begin
         if (sync) begin
            phase = 1'b0;
         end else if (endf) begin
            flush_message();
         end else if (ok) begin
            half = {slow[7:0], slow[15:8], slow[23:16]} ^ key;
            if (!phase) begin
               held  = half;
               phase = 1'b1;
            end else begin
               phase = 1'b0;
               block = {held, half};
               if ((block[47:40] & mask) == gps) begin
                  cnt = int'(block[42:40]);
                  if (cnt > MAX_PAYLOAD) cnt = int'(MAX_PAYLOAD);
                  for (int i = 1; i <= cnt; i++) begin
                     b   = block[47-8*i -: 8];
                     hit = (recent == EOB_HEAD) && (b == EOB_TAIL);
                     if (hit) begin
                        recent  = '0;
                        pending = 1'b0;
                     end else begin
                        recent  = {recent[23:0], b};
                        pending = 1'b1;
                     end
                     gps_out_q.push_back('{data: b, byte_valid: 1'b1, message_end: hit,
                                           tail: (i == cnt)});
                  end
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      gps_result_type want;
      if (reset) begin
         key     = KEY_RESET;
         mask    = MASK_RESET;
         gps     = GPS_RESET;
         phase   = 1'b0;
         held    = '0;
         recent  = '0;
         pending = 1'b0;
         gps_out_q.delete();
      end else begin
         // results first, so a request accepted on this edge cannot satisfy them
         if (rsp_tvalid && rsp_tready) begin
            if (gps_out_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual data %0h user %0b last %0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = gps_out_q.pop_front();
               check_field("out_byte", want.data, rsp_tdata);
               check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, rsp_tuser[0]});
               check_field("message_end", {7'd0, want.message_end}, {7'd0, rsp_tuser[1]});
               check_field("last_of_input", {7'd0, want.tail}, {7'd0, rsp_tlast});
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY:  key  = csr_data;
               CSR_MASK: mask = csr_data[7:0];
               CSR_GPS:  gps  = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            deframe_request(req_tuser[1:0], req_tuser[2], req_tuser[3], req_tlast, req_tdata);
         end
      end
      outstanding <= gps_out_q.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed slow-data requests and register writes into the GPS deframer
// under random idling on both channels; a separate checker predicts and
// compares the results, and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import sdgd_pkg::*;

   // action code the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // cycles of quiet after the last result before a write or the verdict
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   int          fail_count;
   int          outstanding;
   int          cycles = 0;
   int          requests_sent = 0;
   bit          stall_on = 1'b1;

   // our own view of the registers, used only to build well-formed blocks
   logic [23:0] key_shadow  = KEY_RESET;
   logic [7:0]  mask_shadow = MASK_RESET;
   logic [7:0]  gps_shadow  = GPS_RESET;

   slow_data_gps_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sdgd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // give up on a hung block
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: stall in random bursts while stalling is enabled
   initial begin
      @(negedge reset);
      forever begin
         if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Present one request and hold it until accepted. An optional idle burst
   // comes first; valid is never lowered and raised within one step.
   task automatic send_req(input logic [1:0] act, input logic ok, input logic sync,
                           input logic endf, input logic [23:0] slow);
      if (stall_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= slow;
      req_tuser  <= {sync, ok, act};
      req_tlast  <= endf;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // scramble a plain half block into the request data layout
   function automatic logic [23:0] scramble(input logic [23:0] plain);
      logic [23:0] x;
      x = plain ^ key_shadow;
      return {x[7:0], x[15:8], x[23:16]};
   endfunction

   task automatic send_block(input logic [47:0] plain);
      send_req(ACT_VOICE, 1'b1, 1'b0, 1'b0, scramble(plain[47:24]));
      send_req(ACT_VOICE, 1'b1, 1'b0, 1'b0, scramble(plain[23:0]));
   endtask

   // Build a block whose type matches the current setting; the count lands in
   // the low bits wherever the mask leaves them free.
   task automatic send_gps(input logic [2:0] count, input logic [39:0] payload);
      logic [7:0] r;
      r      = 8'($urandom);
      r[2:0] = count;
      send_block({(gps_shadow & mask_shadow) | (r & ~mask_shadow), payload});
   endtask

   // Drop valid and hold off until every expected result has been taken,
   // then let the block settle on items that leave no result.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Present one write and hold it until taken; the caller drops valid
   // after its last write.
   task automatic write_csr(input logic [1:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY:  key_shadow  = value;
         CSR_MASK: mask_shadow = value[7:0];
         CSR_GPS:  gps_shadow  = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [23:0] k, input logic [7:0] m, input logic [7:0] g);
      wait_drained();
      write_csr(CSR_KEY, k);
      write_csr(CSR_MASK, {16'h0, m});
      write_csr(CSR_GPS, {16'h0, g});
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed GPS blocks with random content, seasoned with marker
   // text, flush triggers, short frames, stray halves and raw noise.
   task automatic random_traffic(input int n);
      int stop;
      stop = requests_sent + n;
      while (requests_sent < stop) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
               if ($urandom_range(0, 2) == 0)
                  send_req(ACT_VOICE, 1'b1, 1'b1, 1'b0, 24'($urandom));
               case ($urandom_range(0, 3))
                  0: send_gps(3'd5, 40'h5B454F425D);
                  1: send_gps(3'($urandom_range(5, 7)), {8'h00, EOB_HEAD});
                  2: send_gps(3'($urandom_range(1, 5)), {EOB_TAIL, 32'($urandom)});
                  default: send_gps(3'($urandom_range(0, 7)), {8'($urandom), 32'($urandom)});
               endcase
            end
            10: send_req(ACT_VOICE, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 24'($urandom));
            11: send_req(ACT_HEADER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 24'($urandom));
            12: send_req(ACT_EOT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 24'($urandom));
            13: send_req(ACT_VOICE, 1'($urandom_range(0, 1)), 1'b0, 1'b1, 24'($urandom));
            14: send_req(ACT_VOICE, 1'b0, 1'b0, 1'b0, 24'($urandom));
            15, 16: send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             24'($urandom));
            17: send_block({16'($urandom), 32'($urandom)});
            18: send_req(ACT_VOICE, 1'($urandom_range(0, 1)), 1'b1, 1'b1, 24'($urandom));
            default: send_req(ACT_VOICE, 1'b1, 1'b0, 1'b0, 24'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset settings
      send_req(ACT_VOICE, 1'b1, 1'b1, 1'b0, 24'h000000);        // sync, no result
      send_gps(3'd5, 40'h5B454F425D);                          // marker inside one block
      send_gps(3'd3, {24'h616263, 16'h0});                      // leaves bytes pending
      send_req(ACT_HEADER, 1'b0, 1'b0, 1'b0, 24'hFFFFFF);       // flush on header
      send_gps(3'd7, {8'h00, EOB_HEAD});                        // count clamps, zero ahead
      send_gps(3'd1, {EOB_TAIL, 32'h0});                        // marker across blocks
      send_gps(3'd0, 40'hFFFFFFFFFF);                           // zero count
      send_block({8'h45, 40'h1122334455});                      // not a GPS block
      send_gps(3'd2, {16'h7879, 24'h0});
      send_req(ACT_VOICE, 1'b1, 1'b0, 1'b1, 24'h000000);        // flush on end frame
      send_gps(3'd1, {8'h7A, 32'h0});
      send_req(ACT_EOT, 1'b1, 1'b1, 1'b1, 24'hFFFFFF);          // flush on end of stream
      send_req(ACT_EOT, 1'b0, 1'b0, 1'b0, 24'h000000);          // nothing pending
      // a short frame between the halves is skipped
      send_req(ACT_VOICE, 1'b1, 1'b0, 1'b0, scramble(24'h343132));
      send_req(ACT_VOICE, 1'b0, 1'b0, 1'b0, 24'hFFFFFF);
      send_req(ACT_VOICE, 1'b1, 1'b0, 1'b0, scramble(24'h333435));
      // sync beats end and restarts the pairing after a stray half
      send_req(ACT_VOICE, 1'b1, 1'b0, 1'b0, scramble(24'h314141));
      send_req(ACT_VOICE, 1'b1, 1'b1, 1'b1, 24'hFFFFFF);
      send_gps(3'd1, {8'h42, 32'h0});
      send_req(ACT_UNUSED, 1'b1, 1'b1, 1'b1, 24'hFFFFFF);       // ignored action
      send_req(ACT_EOT, 1'b0, 1'b0, 1'b0, 24'h000000);

      random_traffic(20);

      // exact type match, count clamps to five, no scrambling
      set_registers(24'h000000, 8'hFF, 8'hFF);
      random_traffic(20);

      // every block is GPS, all key bits set
      set_registers(24'hFFFFFF, 8'h00, 8'h00);
      random_traffic(20);

      // random key and type nibble, no idling in the final stretch
      set_registers(24'($urandom), MASK_RESET, {4'($urandom), 4'h0});
      stall_on = 1'b0;
      random_traffic(20);

      wait_drained();
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
